// File: hdl/sdm_pkg.sv
// sdm_pkg: types, codes and constants shared by the slab density map.
// No dependencies; used by every module of the block.
package sdm_pkg;

   // Grid defaults
   localparam int Y_BINS_DEFAULT = 512;
   localparam int Z_BINS_DEFAULT = 512;
   localparam int BINS_MAX       = 1024;

   // Field widths
   localparam int TYPE_W  = 8;
   localparam int POS_W   = 16;
   localparam int RBIN_W  = 9;
   localparam int COUNT_W = 20;
   localparam int BIN_W   = 11;          // rounded index, 0 .. 1024
   localparam int PROD_W  = 2 * BIN_W;   // y * Z_BINS + z, before trimming
   localparam int CSR_W   = 16;
   localparam int CSR_IDX_W = 2;

   // Q10.6 rounding
   localparam int FRAC_BITS = 6;
   localparam logic [POS_W:0] HALF_LSB = (POS_W + 1)'(32);

   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

   // Register indexes and reset values
   localparam logic [CSR_IDX_W-1:0] CSR_TARGET_TYPE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SLAB_LOW    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SLAB_HIGH   = 2'd2;

   localparam logic [TYPE_W-1:0] TARGET_TYPE_RESET = 8'd6;
   localparam logic [POS_W-1:0]  SLAB_LOW_RESET    = 16'd7936;   // 124.0
   localparam logic [POS_W-1:0]  SLAB_HIGH_RESET   = 16'd23296;  // 364.0

   // Queue between front and back
   localparam int QUEUE_DEPTH = 4;

   typedef enum logic {
      CMD_ADD  = 1'b0,
      CMD_READ = 1'b1
   } cmd_type;

   // Work that the back end carries out
   typedef enum logic [1:0] {
      OP_ADD       = 2'd0,   // count one atom
      OP_DROP      = 2'd1,   // atom outside grid, set drop flag
      OP_READ      = 2'd2,   // read and clear one bin
      OP_READ_NONE = 2'd3    // read outside grid, returns zero
   } op_kind_type;

   localparam int OP_KIND_W = 2;

   typedef struct packed {
      cmd_type            cmd;
      logic [TYPE_W-1:0]  atom_type;
      logic [POS_W-1:0]   pos_x;
      logic [POS_W-1:0]   pos_y;
      logic [POS_W-1:0]   pos_z;
      logic [RBIN_W-1:0]  read_y_bin;
      logic [RBIN_W-1:0]  read_z_bin;
   } req_type;

   typedef struct packed {
      logic [COUNT_W-1:0] bin_count;
      logic               drop_seen;
   } rsp_type;

endpackage

// File: hdl/sdm_front.sv
// sdm_front: register file, request capture and classification of each transaction.
// Depends on sdm_pkg. Feeds sdm_queue with one packed op per pushed transaction.
module sdm_front #(
   parameter int Y_BINS = sdm_pkg::Y_BINS_DEFAULT,
   parameter int Z_BINS = sdm_pkg::Z_BINS_DEFAULT,
   parameter int ADDR_W = 18
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  accept,
   input  sdm_pkg::req_type                      req_payload,
   input  logic                                  csr_we,
   input  logic [sdm_pkg::CSR_IDX_W-1:0]         csr_index,
   input  logic [sdm_pkg::CSR_W-1:0]             csr_wdata,
   output logic                                  push,
   output logic [sdm_pkg::OP_KIND_W+ADDR_W-1:0]  push_data
);

   localparam logic [sdm_pkg::BIN_W-1:0]  Y_LIMIT = sdm_pkg::BIN_W'(Y_BINS);
   localparam logic [sdm_pkg::BIN_W-1:0]  Z_LIMIT = sdm_pkg::BIN_W'(Z_BINS);
   localparam logic [sdm_pkg::PROD_W-1:0] Z_MULT  = sdm_pkg::PROD_W'(Z_BINS);

   logic [sdm_pkg::TYPE_W-1:0] target_type_ff;
   logic [sdm_pkg::POS_W-1:0]  slab_low_ff;
   logic [sdm_pkg::POS_W-1:0]  slab_high_ff;
   sdm_pkg::req_type           req_ff;
   logic                       req_valid_ff;

   logic [sdm_pkg::POS_W:0]    y_sum;
   logic [sdm_pkg::POS_W:0]    z_sum;
   logic [sdm_pkg::BIN_W-1:0]  y_bin;
   logic [sdm_pkg::BIN_W-1:0]  z_bin;
   logic                       in_grid;
   logic                       selected;
   logic [sdm_pkg::PROD_W-1:0] bin_index;
   sdm_pkg::op_kind_type       kind;

   always_ff @(posedge clock) begin
      if (reset) begin
         target_type_ff <= sdm_pkg::TARGET_TYPE_RESET;
         slab_low_ff    <= sdm_pkg::SLAB_LOW_RESET;
         slab_high_ff   <= sdm_pkg::SLAB_HIGH_RESET;
         req_valid_ff   <= 1'b0;
      end else begin
         if (csr_we) begin
            unique case (csr_index)
               sdm_pkg::CSR_TARGET_TYPE: target_type_ff <= csr_wdata[sdm_pkg::TYPE_W-1:0];
               sdm_pkg::CSR_SLAB_LOW:    slab_low_ff    <= csr_wdata;
               sdm_pkg::CSR_SLAB_HIGH:   slab_high_ff   <= csr_wdata;
               default: ;
            endcase
         end
         req_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         req_ff <= req_payload;
      end
   end

   // Bin selection: rounded position for add, given bin for read
   always_comb begin
      y_sum = {1'b0, req_ff.pos_y} + sdm_pkg::HALF_LSB;
      z_sum = {1'b0, req_ff.pos_z} + sdm_pkg::HALF_LSB;
      if (req_ff.cmd == sdm_pkg::CMD_READ) begin
         y_bin = sdm_pkg::BIN_W'(req_ff.read_y_bin);
         z_bin = sdm_pkg::BIN_W'(req_ff.read_z_bin);
      end else begin
         y_bin = y_sum[sdm_pkg::POS_W:sdm_pkg::FRAC_BITS];
         z_bin = z_sum[sdm_pkg::POS_W:sdm_pkg::FRAC_BITS];
      end
      in_grid   = (y_bin < Y_LIMIT) && (z_bin < Z_LIMIT);
      bin_index = sdm_pkg::PROD_W'(y_bin) * Z_MULT + sdm_pkg::PROD_W'(z_bin);
      selected  = (req_ff.atom_type == target_type_ff)
                  && (slab_low_ff < req_ff.pos_x) && (req_ff.pos_x < slab_high_ff);

      if (req_ff.cmd == sdm_pkg::CMD_READ) begin
         kind = in_grid ? sdm_pkg::OP_READ : sdm_pkg::OP_READ_NONE;
         push = req_valid_ff;
      end else begin
         kind = in_grid ? sdm_pkg::OP_ADD : sdm_pkg::OP_DROP;
         push = req_valid_ff && selected;
      end
      push_data = {kind, bin_index[ADDR_W-1:0]};
   end

endmodule

// File: hdl/sdm_queue.sv
// sdm_queue: small register FIFO between classification and bin update.
// Depends on sdm_pkg for its default depth.
module sdm_queue #(
   parameter int WIDTH = 20,
   parameter int DEPTH = sdm_pkg::QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   input  logic             pop,
   output logic             pop_valid,
   output logic [WIDTH-1:0] pop_data,
   output logic             almost_full
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [CNT_W-1:0] FULL_LEVEL = CNT_W'(DEPTH);
   // Room kept for one transaction in capture and one being accepted
   localparam logic [CNT_W-1:0] HIGH_LEVEL = CNT_W'(DEPTH - 2);

   logic [WIDTH-1:0] entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff;
   logic [PTR_W-1:0] rd_ptr_ff;
   logic [CNT_W-1:0] count_ff;
   logic             do_pop;

   assign pop_valid   = (count_ff != '0);
   assign pop_data    = entry_ff[rd_ptr_ff];
   assign almost_full = (count_ff >= HIGH_LEVEL);
   assign do_pop      = pop && pop_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (push && !do_pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (!push && do_pop) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(push && !do_pop && count_ff == FULL_LEVEL))
      else $error("queue overflow");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0) |=> (count_ff <= CNT_W'(1)))
      else $error("queue level jumped from empty");

endmodule

// File: hdl/sdm_back.sv
// sdm_back: bin store with read-modify-write, forwarding, clearing pass and results.
// Depends on sdm_pkg. Takes packed ops from sdm_queue.
module sdm_back #(
   parameter int Y_BINS = sdm_pkg::Y_BINS_DEFAULT,
   parameter int Z_BINS = sdm_pkg::Z_BINS_DEFAULT,
   parameter int ADDR_W = 18
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 op_valid,
   input  logic [sdm_pkg::OP_KIND_W+ADDR_W-1:0] op_data,
   output logic                                 pop,
   output logic                                 clearing,
   output logic                                 rsp_valid,
   output sdm_pkg::rsp_type                     rsp_payload
);

   localparam int DEPTH = Y_BINS * Z_BINS;
   localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);

   typedef enum logic {
      ST_CLEAR,
      ST_RUN
   } state_type;

   logic [sdm_pkg::COUNT_W-1:0] mem [DEPTH];

   state_type                   state_ff;
   logic [ADDR_W-1:0]           clr_addr_ff;
   logic [sdm_pkg::COUNT_W-1:0] rd_data_ff;
   logic                        s1_valid_ff;
   sdm_pkg::op_kind_type        s1_kind_ff;
   logic [ADDR_W-1:0]           s1_addr_ff;
   logic                        wb_valid_ff;
   logic [ADDR_W-1:0]           wb_addr_ff;
   logic [sdm_pkg::COUNT_W-1:0] wb_data_ff;
   logic                        drop_ff;
   logic                        rsp_valid_ff;
   sdm_pkg::rsp_type            rsp_ff;

   sdm_pkg::op_kind_type        op_kind;
   logic [ADDR_W-1:0]           op_addr;
   logic [sdm_pkg::COUNT_W-1:0] old_count;
   logic [sdm_pkg::COUNT_W-1:0] new_count;
   logic                        upd_we;
   logic                        is_read;
   logic                        mem_we;
   logic [ADDR_W-1:0]           mem_waddr;
   logic [sdm_pkg::COUNT_W-1:0] mem_wdata;

   assign op_kind  = sdm_pkg::op_kind_type'(op_data[sdm_pkg::OP_KIND_W+ADDR_W-1 -: sdm_pkg::OP_KIND_W]);
   assign op_addr  = op_data[ADDR_W-1:0];
   assign clearing = (state_ff == ST_CLEAR);
   assign pop      = op_valid && (state_ff == ST_RUN);

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // Forward the write of the previous op; the store read missed it
   always_comb begin
      old_count = (wb_valid_ff && wb_addr_ff == s1_addr_ff) ? wb_data_ff : rd_data_ff;
      is_read   = (s1_kind_ff == sdm_pkg::OP_READ) || (s1_kind_ff == sdm_pkg::OP_READ_NONE);
      upd_we    = 1'b0;
      new_count = old_count;
      unique case (s1_kind_ff)
         sdm_pkg::OP_ADD: begin
            upd_we    = s1_valid_ff;
            new_count = (old_count == sdm_pkg::COUNT_MAX) ? old_count : old_count + 1'b1;
         end
         sdm_pkg::OP_READ: begin
            upd_we    = s1_valid_ff;
            new_count = '0;
         end
         sdm_pkg::OP_DROP, sdm_pkg::OP_READ_NONE: begin
            upd_we    = 1'b0;
         end
         default: ;
      endcase
      if (state_ff == ST_CLEAR) begin
         mem_we    = 1'b1;
         mem_waddr = clr_addr_ff;
         mem_wdata = '0;
      end else begin
         mem_we    = upd_we;
         mem_waddr = s1_addr_ff;
         mem_wdata = new_count;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= mem[op_addr];
   end

   // Payload registers of the pipe
   always_ff @(posedge clock) begin
      s1_kind_ff <= op_kind;
      s1_addr_ff <= op_addr;
      wb_addr_ff <= s1_addr_ff;
      wb_data_ff <= new_count;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_addr_ff  <= '0;
         s1_valid_ff  <= 1'b0;
         wb_valid_ff  <= 1'b0;
         drop_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         rsp_ff       <= '0;
      end else begin
         unique case (state_ff)
            ST_CLEAR: begin
               clr_addr_ff <= clr_addr_ff + 1'b1;
               if (clr_addr_ff == LAST_ADDR) begin
                  state_ff <= ST_RUN;
               end
            end
            ST_RUN: ;
            default: state_ff <= ST_CLEAR;
         endcase
         s1_valid_ff  <= pop;
         wb_valid_ff  <= upd_we;
         if (s1_valid_ff && s1_kind_ff == sdm_pkg::OP_DROP) begin
            drop_ff <= 1'b1;
         end
         rsp_valid_ff <= s1_valid_ff && is_read;
         if (s1_valid_ff && is_read) begin
            rsp_ff.bin_count <= (s1_kind_ff == sdm_pkg::OP_READ) ? old_count : '0;
            rsp_ff.drop_seen <= drop_ff;
         end
      end
   end

   a_no_work_in_clear: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CLEAR) |-> !pop && !s1_valid_ff)
      else $error("op issued during clearing pass");

   a_rsp_from_read: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> $past(s1_valid_ff && is_read))
      else $error("result without a read op");

   a_drop_sticky: assert property (@(posedge clock) disable iff (reset)
      $fell(drop_ff) |-> $past(reset))
      else $error("drop flag cleared without reset");

   a_add_no_rsp: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && (s1_kind_ff == sdm_pkg::OP_ADD || s1_kind_ff == sdm_pkg::OP_DROP))
      |=> !rsp_valid_ff)
      else $error("add op produced a result");

endmodule

// File: hdl/slab_density_map.sv
// slab_density_map: top level of the 2D density map over a slab of atoms.
// A read transaction's result passes the capture register, the queue, the s1
//   stage and the result register in turn; adds give no result. Throughput:
//   one transaction per cycle while busy is low, set by the read-modify-write
//   of the bin store with one-deep forwarding. Reset: registers take their
//   reset values, then a clearing pass zeroes the store with busy high.
//   CSR writes are taken during the pass. The receiver cannot stall results.
module slab_density_map #(
   parameter int Y_BINS = sdm_pkg::Y_BINS_DEFAULT,
   parameter int Z_BINS = sdm_pkg::Z_BINS_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   // Request transactions
   input  logic                          start,
   output logic                          busy,
   input  sdm_pkg::req_type              req_payload,
   // Results, one per read transaction
   output logic                          rsp_valid,
   output sdm_pkg::rsp_type              rsp_payload,
   // Register writes
   input  logic                          csr_we,
   input  logic [sdm_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [sdm_pkg::CSR_W-1:0]     csr_wdata
);

   // Store address covers the whole grid, row-major in y
   localparam int DEPTH  = Y_BINS * Z_BINS;
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int OP_W   = sdm_pkg::OP_KIND_W + ADDR_W;

   logic            accept;
   logic            push;
   logic [OP_W-1:0] push_data;
   logic            pop;
   logic            op_valid;
   logic [OP_W-1:0] op_data;
   logic            almost_full;
   logic            clearing;

   // Hold off new transactions while the store is cleared or the queue is
   // close to full; the back end drains one op per cycle, so once the pass
   // is done the queue never holds more than one op and the latter never fires.
   assign busy   = clearing || almost_full;
   assign accept = start && !busy;

   // Front: registers, capture, filter on type and slab, bin rounding
   sdm_front #(
      .Y_BINS (Y_BINS),
      .Z_BINS (Z_BINS),
      .ADDR_W (ADDR_W)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .req_payload (req_payload),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .push        (push),
      .push_data   (push_data)
   );

   // Decouples classification from the store update
   sdm_queue #(
      .WIDTH (OP_W),
      .DEPTH (sdm_pkg::QUEUE_DEPTH)
   ) u_queue (
      .clock       (clock),
      .reset       (reset),
      .push        (push),
      .push_data   (push_data),
      .pop         (pop),
      .pop_valid   (op_valid),
      .pop_data    (op_data),
      .almost_full (almost_full)
   );

   // Back: bin store, counting, read-and-clear, drop flag, result register
   sdm_back #(
      .Y_BINS (Y_BINS),
      .Z_BINS (Z_BINS),
      .ADDR_W (ADDR_W)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .op_valid    (op_valid),
      .op_data     (op_data),
      .pop         (pop),
      .clearing    (clearing),
      .rsp_valid   (rsp_valid),
      .rsp_payload (rsp_payload)
   );

endmodule

// File: verif/density_checker.sv
// density_checker: watches the request, result and CSR ports of slab_density_map,
// keeps a shadow bin store, and compares every read result with its prediction.
// Depends on sdm_pkg for the payload types, field widths and register indexes.
module density_checker import sdm_pkg::*; #(
   parameter int Y_BINS = Y_BINS_DEFAULT,
   parameter int Z_BINS = Z_BINS_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic                 busy,
   input  req_type              req_payload,
   input  logic                 rsp_valid,
   input  rsp_type              rsp_payload,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_W-1:0]     csr_wdata,
   output int                   fail_count,
   output int                   pending
);
   timeunit 1ns;
   timeprecision 1ps;

   bit [COUNT_W-1:0] bin_tally [Y_BINS*Z_BINS];
   bit               drop_latch;
   bit [TYPE_W-1:0]  match_type;
   bit [POS_W-1:0]   slab_lo;
   bit [POS_W-1:0]   slab_hi;
   rsp_type          read_results [$];

   initial begin
      fail_count = 0;
      pending    = 0;
   end

   // Q10.6 position rounded half up to a whole bin, 0 .. 1024
   function automatic int round_bin(input logic [POS_W-1:0] pos);
      logic [POS_W:0] sum;
      sum = {1'b0, pos} + HALF_LSB;
      return int'(sum >> FRAC_BITS);
   endfunction

   task automatic predict_request(input req_type req);
      int      yb;
      int      zb;
      int      idx;
      rsp_type res;
      if (req.cmd == CMD_ADD) begin
         if (req.atom_type == match_type && slab_lo < req.pos_x && req.pos_x < slab_hi) begin
            yb = round_bin(req.pos_y);
            zb = round_bin(req.pos_z);
            if (yb >= Y_BINS || zb >= Z_BINS) begin
               drop_latch = 1'b1;
            end else begin
               idx = yb * Z_BINS + zb;
               if (bin_tally[idx] != COUNT_MAX) bin_tally[idx] = bin_tally[idx] + 1'b1;
            end
         end
      end else begin
         res.bin_count = '0;
         if (int'(req.read_y_bin) < Y_BINS && int'(req.read_z_bin) < Z_BINS) begin
            idx = int'(req.read_y_bin) * Z_BINS + int'(req.read_z_bin);
            res.bin_count = bin_tally[idx];
            bin_tally[idx] = '0;
         end
         res.drop_seen = drop_latch;
         read_results.push_back(res);
      end
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         foreach (bin_tally[i]) bin_tally[i] = '0;
         drop_latch = 1'b0;
         match_type = TARGET_TYPE_RESET;
         slab_lo    = SLAB_LOW_RESET;
         slab_hi    = SLAB_HIGH_RESET;
         read_results.delete();
      end else begin
         // results are older than anything accepted at this edge
         if (rsp_valid) begin
            if (read_results.size() == 0) begin
               $display("%0t: unexpected result, expected none, got count %0d drop %0b",
                        $time, rsp_payload.bin_count, rsp_payload.drop_seen);
               fail_count++;
            end else begin
               want = read_results.pop_front();
               if (rsp_payload.bin_count !== want.bin_count) begin
                  $display("%0t: bin_count expected %0d, got %0d",
                           $time, want.bin_count, rsp_payload.bin_count);
                  fail_count++;
               end
               if (rsp_payload.drop_seen !== want.drop_seen) begin
                  $display("%0t: drop_seen expected %0b, got %0b",
                           $time, want.drop_seen, rsp_payload.drop_seen);
                  fail_count++;
               end
            end
         end
         if (csr_we) begin
            case (csr_index)
               CSR_TARGET_TYPE: match_type = csr_wdata[TYPE_W-1:0];
               CSR_SLAB_LOW:    slab_lo    = csr_wdata;
               CSR_SLAB_HIGH:   slab_hi    = csr_wdata;
               default: ;
            endcase
         end
         if (start && !busy) predict_request(req_payload);
      end
      pending = read_results.size();
   end

endmodule

// File: verif/tb.sv
// tb: stimulus and verdict for slab_density_map; density_checker does the checking.
// Depends on sdm_pkg, slab_density_map and density_checker.
module tb import sdm_pkg::*;;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int RSP_LATENCY     = 3;     // start edge to result strobe
   localparam int PHASES          = 5;
   localparam int ITEMS_PER_PHASE = 350;
   // Index past the register list; the block must ignore writes to it
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE = 2'd3;

   logic                 clock       = 1'b0;
   logic                 reset       = 1'b1;
   logic                 start       = 1'b0;
   logic                 busy;
   req_type              req_payload = '0;
   logic                 rsp_valid;
   rsp_type              rsp_payload;
   logic                 csr_we      = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index   = CSR_TARGET_TYPE;
   logic [CSR_W-1:0]     csr_wdata   = '0;
   int                   fail_count;
   int                   pending;

   // Register values currently loaded, used to aim the random atoms
   logic [TYPE_W-1:0]    cfg_type = TARGET_TYPE_RESET;
   logic [POS_W-1:0]     cfg_lo   = SLAB_LOW_RESET;
   logic [POS_W-1:0]     cfg_hi   = SLAB_HIGH_RESET;

   slab_density_map #(
      .Y_BINS(Y_BINS_DEFAULT),
      .Z_BINS(Z_BINS_DEFAULT)
   ) dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_payload(req_payload),
      .rsp_valid(rsp_valid),
      .rsp_payload(rsp_payload),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   density_checker #(
      .Y_BINS(Y_BINS_DEFAULT),
      .Z_BINS(Z_BINS_DEFAULT)
   ) density_check (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_payload(req_payload),
      .rsp_valid(rsp_valid),
      .rsp_payload(rsp_payload),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata),
      .fail_count(fail_count),
      .pending(pending)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   // Hard stop. The slowest legal run is the reset clearing pass plus the
   // traffic, well under a third of this.
   initial begin
      #4000000;
      $display("[slab_density_map] ERROR");
      $finish;
   end

   // Every field random; callers then set the fields the command uses, so the
   // unused fields carry noise the block must ignore.
   function automatic req_type noise_req();
      req_type r;
      r.cmd        = cmd_type'($urandom_range(1));
      r.atom_type  = TYPE_W'($urandom);
      r.pos_x      = POS_W'($urandom);
      r.pos_y      = POS_W'($urandom);
      r.pos_z      = POS_W'($urandom);
      r.read_y_bin = RBIN_W'($urandom);
      r.read_z_bin = RBIN_W'($urandom);
      return r;
   endfunction

   function automatic req_type atom_req(input int t, input int x, input int y, input int z);
      req_type r;
      r           = noise_req();
      r.cmd       = CMD_ADD;
      r.atom_type = TYPE_W'(t);
      r.pos_x     = POS_W'(x);
      r.pos_y     = POS_W'(y);
      r.pos_z     = POS_W'(z);
      return r;
   endfunction

   function automatic req_type read_req(input int yb, input int zb);
      req_type r;
      r            = noise_req();
      r.cmd        = CMD_READ;
      r.read_y_bin = RBIN_W'(yb);
      r.read_z_bin = RBIN_W'(zb);
      return r;
   endfunction

   // A position that rounds to bin b: anywhere in [b*64-32, b*64+31]
   function automatic logic [POS_W-1:0] pos_near(input int b);
      int p;
      p = b * 64 + int'($urandom_range(63)) - 32;
      if (p < 0) p = 0;
      if (p > 65535) p = 65535;
      return POS_W'(p);
   endfunction

   // Mostly well-formed traffic: adds of the counted type inside the slab,
   // landing on a 4x4 window of bins, and reads of that same window so that
   // counts build up, get forwarded and get cleared. The rest is noise.
   function automatic req_type random_req(input int wy, input int wz);
      req_type r;
      int      lo_i;
      int      hi_i;
      int      pick;
      r    = noise_req();
      lo_i = int'(cfg_lo);
      hi_i = int'(cfg_hi);
      if ($urandom_range(99) < 60) begin
         r.cmd = CMD_ADD;
         if ($urandom_range(99) < 85) r.atom_type = cfg_type;
         pick = $urandom_range(99);
         if (pick < 75 && hi_i > lo_i + 1) begin
            r.pos_x = POS_W'($urandom_range(hi_i - 1, lo_i + 1));
         end else if (pick < 90) begin
            // slab edges: the limits themselves are outside
            case ($urandom_range(3))
               0: r.pos_x = cfg_lo;
               1: r.pos_x = cfg_hi;
               2: r.pos_x = cfg_lo + 1'b1;
               default: r.pos_x = cfg_hi - 1'b1;
            endcase
         end
         if ($urandom_range(99) < 80) begin
            r.pos_y = pos_near(wy + int'($urandom_range(3)));
            r.pos_z = pos_near(wz + int'($urandom_range(3)));
         end
      end else begin
         r.cmd = CMD_READ;
         if ($urandom_range(99) < 80) begin
            r.read_y_bin = RBIN_W'(wy + int'($urandom_range(3)));
            r.read_z_bin = RBIN_W'(wz + int'($urandom_range(3)));
         end
      end
      return r;
   endfunction

   // Present one transaction at the falling edge and hold it until accepted.
   // start stays high on return so a back-to-back transaction does not toggle it.
   task automatic issue(input req_type r);
      start       <= 1'b1;
      req_payload <= r;
      @(posedge clock);
      while (busy) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic idle_gap(input int pct);
      while ($urandom_range(99) < pct) begin
         start <= 1'b0;
         @(negedge clock);
      end
   endtask

   // Hold the sender until every read has returned, then let the pipe empty,
   // since adds leave no result to wait for.
   task automatic settle();
      start <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (RSP_LATENCY + 2) @(negedge clock);
   endtask

   // Writes the spare index first (random data, must be ignored), then the
   // three real registers. target_type gets random upper bits.
   task automatic load_slab(input logic [TYPE_W-1:0] t, input logic [POS_W-1:0] lo,
                            input logic [POS_W-1:0] hi);
      csr_we    <= 1'b1;
      csr_index <= CSR_SPARE;
      csr_wdata <= CSR_W'($urandom);
      @(negedge clock);
      csr_index <= CSR_TARGET_TYPE;
      csr_wdata <= {8'($urandom), t};
      @(negedge clock);
      csr_index <= CSR_SLAB_LOW;
      csr_wdata <= lo;
      @(negedge clock);
      csr_index <= CSR_SLAB_HIGH;
      csr_wdata <= hi;
      @(negedge clock);
      csr_we   <= 1'b0;
      cfg_type = t;
      cfg_lo   = lo;
      cfg_hi   = hi;
   endtask

   initial begin
      req_type          directed [$];
      int               wy;
      int               wz;
      int               idle_pct;
      logic [TYPE_W-1:0] t;
      logic [POS_W-1:0] lo;
      logic [POS_W-1:0] hi;

      repeat (5) @(negedge clock);
      reset <= 1'b0;

      // Directed transactions, run against the reset register values.
      // issue() waits out the clearing pass through busy.
      directed.push_back(read_req(0, 0));                                 // empty store
      directed.push_back(atom_req(TARGET_TYPE_RESET, SLAB_LOW_RESET + 1, 0, 0));
      directed.push_back(atom_req(TARGET_TYPE_RESET, SLAB_LOW_RESET, 0, 0));   // on low limit
      directed.push_back(atom_req(TARGET_TYPE_RESET, SLAB_HIGH_RESET, 0, 0));  // on high limit
      directed.push_back(atom_req(TARGET_TYPE_RESET, SLAB_HIGH_RESET - 1, 31, 32)); // (0,1)
      directed.push_back(atom_req(TARGET_TYPE_RESET + 1, 10000, 0, 0));   // other type
      directed.push_back(atom_req(255, 65535, 65535, 65535));             // all ones, ignored
      directed.push_back(read_req(0, 0));                                 // one
      directed.push_back(read_req(0, 0));                                 // cleared by last read
      directed.push_back(atom_req(TARGET_TYPE_RESET, 10000, 32735, 32735)); // last bin
      directed.push_back(atom_req(TARGET_TYPE_RESET, 10000, 32735, 32736)); // z rounds to 512
      directed.push_back(atom_req(TARGET_TYPE_RESET, 10000, 65535, 0));   // y rounds to 1024
      directed.push_back(read_req(511, 511));                             // drop flag now set
      // same bin back to back: add/add, add/read, read/add
      directed.push_back(atom_req(TARGET_TYPE_RESET, 9000, 320, 351));
      directed.push_back(atom_req(TARGET_TYPE_RESET, 9000, 320, 351));
      directed.push_back(read_req(5, 5));
      directed.push_back(atom_req(TARGET_TYPE_RESET, 9000, 288, 320));    // half rounds up
      directed.push_back(read_req(5, 5));
      directed.push_back(atom_req(TARGET_TYPE_RESET, 9000, 320, 351));
      directed.push_back(read_req(5, 5));
      directed.push_back(read_req(0, 1));
      directed.push_back(read_req(511, 0));
      directed.push_back(atom_req(TARGET_TYPE_RESET, SLAB_LOW_RESET + 1, 0, 31));
      directed.push_back(read_req(0, 0));
      foreach (directed[i]) issue(directed[i]);
      settle();

      // Random phases. Sender idles 11% in the first two, 86% in the next
      // two, never in the last. Each phase loads its own slab setting.
      for (int ph = 0; ph < PHASES; ph++) begin
         wy = $urandom_range(510);
         wz = $urandom_range(510);
         case (ph)
            0: begin   // widest slab, lowest type, window on the grid corner
               t = 8'd0;  lo = 16'd0;  hi = 16'hFFFF;
               wy = 0;    wz = 0;
               idle_pct = 11;
            end
            1: begin   // low above high: empty slab, reads drain old counts
               t = 8'hFF; lo = 16'hFFFF; hi = 16'd0;
               idle_pct = 11;
            end
            2: begin   // narrow random slab, window over the far grid edge
               t  = TYPE_W'($urandom);
               lo = POS_W'($urandom_range(30000));
               hi = lo + POS_W'($urandom_range(30000, 1));
               wy = 509;  wz = 510;
               idle_pct = 86;
            end
            3: begin   // back to the power-on setting
               t = TARGET_TYPE_RESET;  lo = SLAB_LOW_RESET;  hi = SLAB_HIGH_RESET;
               idle_pct = 86;
            end
            default: begin
               t  = TYPE_W'($urandom);
               lo = POS_W'($urandom_range(20000));
               hi = POS_W'($urandom_range(65535, 40000));
               idle_pct = 0;
            end
         endcase
         load_slab(t, lo, hi);
         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            // mid-phase the sender stops until every read has returned
            if (n == ITEMS_PER_PHASE / 2) settle();
            idle_gap(idle_pct);
            issue(random_req(wy, wz));
         end
         settle();
      end

      if (fail_count == 0) begin
         $display("[slab_density_map] OK");
      end else begin
         $display("[slab_density_map] ERROR");
      end
      $finish;
   end

endmodule
